[rtl/assert_macros.svh]
// Assertion macros shared by the CAN signal codec RTL.
// Every macro samples on clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define CSBF_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante holds.
`define CSBF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/csbf_pkg.sv]
// Shared types, constants and helpers for the CAN signal bit-field codec.
// No dependencies; used by csbf_prep and can_signal_bit_field_codec.
`default_nettype none

package csbf_pkg;

  localparam int PAYLOAD_BYTES = 8;
  localparam int BYTE_W        = 8;
  localparam int FRAME_W       = 64;
  localparam int WIN_W         = 2 * FRAME_W;
  localparam int START_W       = 6;
  localparam int LEN_W         = 7;
  localparam int SHIFT_W       = 8;
  localparam int FINE_W        = 3;
  localparam int NUM_BYTES     = FRAME_W / BYTE_W;

  // Frame bits that belong to the payload; higher bits pass through untouched.
  localparam logic [FRAME_W-1:0] PAYLOAD_MASK =
    {FRAME_W{1'b1}} >> (FRAME_W - PAYLOAD_BYTES * BYTE_W);

  // Operation selected by the tuser bit of an input beat.
  typedef enum logic {
    KIND_EXTRACT = 1'b0,
    KIND_INSERT  = 1'b1
  } kind_t;

  // Decoded access, registered at the end of the first stage.
  typedef struct packed {
    kind_t              kind;
    logic               is_signed;
    logic               intel;
    logic [LEN_W-1:0]   len;
    logic [FRAME_W-1:0] mask;
    logic [FRAME_W-1:0] frame;
    logic [FRAME_W-1:0] word;
    logic [FRAME_W-1:0] value;
    logic               sat;
    logic [SHIFT_W-1:0] shamt;
  } prep_t;

  // Reverse the byte order of a frame; Motorola fields are linear in this view.
  function automatic logic [FRAME_W-1:0] byte_swap(input logic [FRAME_W-1:0] w);
    logic [FRAME_W-1:0] r;
    r = '0;
    for (int b = 0; b < NUM_BYTES; b++) begin
      r[b*BYTE_W +: BYTE_W] = w[(NUM_BYTES-1-b)*BYTE_W +: BYTE_W];
    end
    return r;
  endfunction

  // Payload bits in the working view (frame order or byte-swapped order).
  function automatic logic [FRAME_W-1:0] payload_view(input logic intel);
    return intel ? PAYLOAD_MASK : byte_swap(PAYLOAD_MASK);
  endfunction

endpackage

`default_nettype wire

[rtl/csbf_prep.sv]
// Access decode for the CAN signal codec: length clamp, field mask,
// saturation, working view of the frame and window shift amount. Uses csbf_pkg.
`default_nettype none

module csbf_prep
  import csbf_pkg::*;
(
  input  kind_t              kind,
  input  logic [FRAME_W-1:0] frame_bytes,
  input  logic [START_W-1:0] start_bit,
  input  logic [LEN_W-1:0]   bit_length,
  input  logic               intel_order,
  input  logic               sign_extend,
  input  logic [FRAME_W-1:0] write_value,
  output prep_t              prep
);

  logic [LEN_W-1:0]   len_c;
  logic [FRAME_W-1:0] mask;
  logic               sat;
  logic [START_W-1:0] msb_lin;

  // Lengths above the frame width act as a full-width field.
  assign len_c = (bit_length > LEN_W'(FRAME_W)) ? LEN_W'(FRAME_W) : bit_length;
  assign mask  = len_c[LEN_W-1] ? {FRAME_W{1'b1}}
                                : ~({FRAME_W{1'b1}} << len_c[START_W-1:0]);

  // A value overflows when any bit at or above the field length is set.
  assign sat = !len_c[LEN_W-1] && (|(write_value >> len_c[START_W-1:0]));

  // Motorola start bit as a position in the byte-swapped, bit-reversed walk.
  assign msb_lin = {start_bit[START_W-1:3], ~start_bit[2:0]};

  // The field sits at window bit 64 + offset; the shift amount is that index.
  always_comb begin
    prep.kind      = kind;
    prep.is_signed = sign_extend;
    prep.intel     = intel_order;
    prep.len       = len_c;
    prep.mask      = mask;
    prep.frame     = frame_bytes;
    prep.word      = intel_order ? frame_bytes : byte_swap(frame_bytes);
    prep.value     = sat ? mask : write_value;
    prep.sat       = sat;
    if (intel_order) begin
      prep.shamt = SHIFT_W'(FRAME_W) + SHIFT_W'(start_bit);
    end else begin
      prep.shamt = SHIFT_W'(WIN_W) - SHIFT_W'(msb_lin) - SHIFT_W'(len_c);
    end
  end

endmodule

`default_nettype wire

[rtl/can_signal_bit_field_codec.sv]
// CAN signal bit-field codec: extracts or inserts one DBC signal in a payload.
// Pipeline stages from input beat to output beat: decode, byte shift,
// bit shift and merge, result register. One beat per cycle unless stalled.
// Each stage moves on its own, so bubbles close up under back-pressure.
// Synchronous active-high rst empties the pipeline; payload is not cleared.
`default_nettype none

module can_signal_bit_field_codec
  import csbf_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // Low to high: frame_bytes[63:0], start_bit[69:64], bit_length[76:70],
  // intel_order[77], sign_extend[78], write_value[142:79], zero pad[143].
  input  logic [143:0] s_tdata,
  // kind: 0 extract, 1 insert.
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // Low to high: raw_value[63:0], extended_value[127:64], frame_out[191:128],
  // saturated[192], zero pad[199:193].
  output logic [199:0] m_tdata
);

  `include "assert_macros.svh"

  // Second stage: window shifted by whole bytes.
  typedef struct packed {
    kind_t              kind;
    logic               is_signed;
    logic               intel;
    logic [LEN_W-1:0]   len;
    logic [FRAME_W-1:0] mask;
    logic [FRAME_W-1:0] frame;
    logic [FRAME_W-1:0] word;
    logic               sat;
    logic [FINE_W-1:0]  fine;
    logic [WIN_W-1:0]   xr;
    logic [WIN_W-1:0]   ml;
    logic [WIN_W-1:0]   vl;
  } st2_t;

  // Third stage: extracted field and merged working word.
  typedef struct packed {
    kind_t              kind;
    logic               is_signed;
    logic               intel;
    logic [LEN_W-1:0]   len;
    logic [FRAME_W-1:0] mask;
    logic [FRAME_W-1:0] frame;
    logic               sat;
    logic [FRAME_W-1:0] raw;
    logic [FRAME_W-1:0] wnew;
  } st3_t;

  prep_t st1_next, st1;
  st2_t  st2_next, st2;
  st3_t  st3_next, st3;

  logic v1, v2, v3, vo;
  logic en1, en2, en3, en_o;

  kind_t              out_kind;
  logic [FRAME_W-1:0] out_raw, out_raw_next;
  logic [FRAME_W-1:0] out_ext, out_ext_next;
  logic [FRAME_W-1:0] out_frame, out_frame_next;
  logic               out_sat, out_sat_next;

  logic [WIN_W-1:0]   win;
  logic [SHIFT_W-1:0] coarse;
  logic [WIN_W-1:0]   xr_f, ml_f, vl_f;
  logic [FRAME_W-1:0] fm;
  logic               sign_neg;

  // Stage enables: a stage loads when it is empty or its successor loads.
  assign en_o     = !vo || m_tready;
  assign en3      = !v3 || en_o;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign s_tready = en1;

  // Stage 1: decode the access.
  csbf_prep u_prep (
    .kind        (kind_t'(s_tuser)),
    .frame_bytes (s_tdata[63:0]),
    .start_bit   (s_tdata[69:64]),
    .bit_length  (s_tdata[76:70]),
    .intel_order (s_tdata[77]),
    .sign_extend (s_tdata[78]),
    .write_value (s_tdata[142:79]),
    .prep        (st1_next)
  );

  // Stage 2: coarse shift of the read window, field mask and value.
  assign win    = {st1.word & payload_view(st1.intel), {FRAME_W{1'b0}}};
  assign coarse = {st1.shamt[SHIFT_W-1:FINE_W], {FINE_W{1'b0}}};

  always_comb begin
    st2_next.kind      = st1.kind;
    st2_next.is_signed = st1.is_signed;
    st2_next.intel     = st1.intel;
    st2_next.len       = st1.len;
    st2_next.mask      = st1.mask;
    st2_next.frame     = st1.frame;
    st2_next.word      = st1.word;
    st2_next.sat       = st1.sat;
    st2_next.fine      = st1.shamt[FINE_W-1:0];
    st2_next.xr        = win >> coarse;
    st2_next.ml        = {{FRAME_W{1'b0}}, st1.mask} << coarse;
    st2_next.vl        = {{FRAME_W{1'b0}}, st1.value} << coarse;
  end

  // Stage 3: fine shift, then read the field or merge the new value.
  assign xr_f = st2.xr >> st2.fine;
  assign ml_f = st2.ml << st2.fine;
  assign vl_f = st2.vl << st2.fine;
  assign fm   = ml_f[WIN_W-1:FRAME_W] & payload_view(st2.intel);

  always_comb begin
    st3_next.kind      = st2.kind;
    st3_next.is_signed = st2.is_signed;
    st3_next.intel     = st2.intel;
    st3_next.len       = st2.len;
    st3_next.mask      = st2.mask;
    st3_next.frame     = st2.frame;
    st3_next.sat       = st2.sat;
    st3_next.raw       = xr_f[FRAME_W-1:0] & st2.mask;
    st3_next.wnew      = (st2.word & ~fm) | (vl_f[WIN_W-1:FRAME_W] & fm);
  end

  // Output stage: sign extension and result selection by kind.
  assign sign_neg = st3.is_signed && (st3.len != '0) && !st3.len[LEN_W-1] &&
                    st3.raw[st3.len[START_W-1:0] - START_W'(1)];

  always_comb begin
    if (st3.kind == KIND_INSERT) begin
      out_raw_next   = '0;
      out_ext_next   = '0;
      out_frame_next = st3.intel ? st3.wnew : byte_swap(st3.wnew);
      out_sat_next   = st3.sat;
    end else begin
      out_raw_next   = st3.raw;
      out_ext_next   = sign_neg ? (st3.raw | ~st3.mask) : st3.raw;
      out_frame_next = st3.frame;
      out_sat_next   = 1'b0;
    end
  end

  // Valid bits of the four stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      vo <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= s_tvalid;
      end
      if (en2) begin
        v2 <= v1;
      end
      if (en3) begin
        v3 <= v2;
      end
      if (en_o) begin
        vo <= v3;
      end
    end
  end

  // Stage payload registers.
  always_ff @(posedge clk) begin
    if (en1) begin
      st1 <= st1_next;
    end
    if (en2) begin
      st2 <= st2_next;
    end
    if (en3) begin
      st3 <= st3_next;
    end
    if (en_o) begin
      out_kind  <= st3.kind;
      out_raw   <= out_raw_next;
      out_ext   <= out_ext_next;
      out_frame <= out_frame_next;
      out_sat   <= out_sat_next;
    end
  end

  assign m_tvalid = vo;
  assign m_tdata  = {7'b0, out_sat, out_frame, out_ext, out_raw};

  // An extract result never reports a clamp.
  `CSBF_ASSERT_IMPLY(a_extract_no_sat, vo && (out_kind == KIND_EXTRACT), !out_sat, "extract flagged saturation")
  // An insert result carries zero read values.
  `CSBF_ASSERT_IMPLY(a_insert_zero_read, vo && (out_kind == KIND_INSERT), (out_raw == '0) && (out_ext == '0), "insert returned read data")
  // A result in the last stage is kept while the output register cannot take it.
  `CSBF_ASSERT_NEXT(a_stage3_held, v3 && !en_o, v3, "stage 3 beat dropped under stall")

endmodule

`default_nettype wire
